[hw/rtl/sfr_pkg.sv]
// Shared types, sizes and register codes of the stream find-and-replace block.
`timescale 1ns / 1ps

package sfr_pkg;

  // Window and replacement capacities in bytes.
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;

  localparam int WIN_DEPTH = MAX_PATTERN;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);
  localparam int LEN_W     = 4;
  localparam int REP_IDX_W = $clog2(MAX_REPLACEMENT);
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_end;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       from_replacement;
    logic       run_last;
    logic       stream_end;
  } sfr_out_t;

  // Window operation broadcast to every cell.
  typedef struct packed {
    logic shift;
    logic clear;
  } sfr_cell_ctl_t;

endpackage

[hw/rtl/sfr_cell.sv]
// One byte cell of the sliding window, with its pattern comparators.
`timescale 1ns / 1ps

module sfr_cell import sfr_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sfr_cell_ctl_t ctl_i,
  input  logic          load_i,
  input  logic [7:0]    load_byte_i,
  input  logic [7:0]    next_byte_i,
  input  logic [7:0]    pat_here_i,
  input  logic [7:0]    pat_prev_i,
  output logic [7:0]    byte_o,
  output logic          eq_here_o,
  output logic          eq_prev_o
);

  logic [7:0] byte_q, byte_d;

  // Clear or shift first, then a new byte may land in the freed slot.
  always_comb begin
    byte_d = byte_q;
    if (ctl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctl_i.shift) begin
      byte_d = next_byte_i;
    end
    if (load_i) begin
      byte_d = load_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o    = byte_q;
  assign eq_here_o = (byte_q == pat_here_i);
  assign eq_prev_o = (byte_q == pat_prev_i);

endmodule

[hw/rtl/sfr_out_buf.sv]
// Two-entry output buffer that decouples the result sequencer from the output stall.
`timescale 1ns / 1ps

module sfr_out_buf import sfr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  sfr_out_t push_data_i,
  output logic     space_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output sfr_out_t out_o
);

  sfr_out_t   ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign out_o       = ent_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  // Space is judged on the registered count only, so the stall never reaches the input.
  assign space_o     = (count_q != 2'd2);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

[hw/rtl/stream_find_and_replace.sv]
// Top level of the streaming find-and-replace block.
`timescale 1ns / 1ps

// Streaming find-and-replace. Text bytes enter one beat at a time; the last
// byte of a text carries text_end. Every leftmost, non-overlapping occurrence
// of the configured pattern (up to eight bytes) is replaced by the configured
// replacement (up to eight bytes, possibly empty). Bytes wait in a sliding
// window built as a row of eight byte cells; each cell compares its byte with
// its pattern byte and with the pattern byte before it, so both the current
// window and the window after one more shift are checked in the same cycle.
// A sequencer emits at most one result beat per cycle, when there is space,
// into a two-entry output buffer. In steady state, with no match pending, one
// byte is accepted and one result is delivered every cycle. A match yields
// the replacement bytes in order, or nothing if the replacement is empty;
// the end of a text flushes the bytes still held in the window, and shortening
// the pattern length mid-text flushes the surplus window bytes. The input
// stalls while such work is pending and whenever the output buffer is full.
// Bytes are registered in the window cells, results in the output buffer.
// run_last marks the last result caused by an input beat and stream_end the
// last result of a text; a text end that causes no byte yields one bare end
// beat with has_byte low. Write configuration only while the block is idle;
// the configuration port is always ready; lengths above eight act as eight.
module stream_find_and_replace import sfr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Text input.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sfr_in_t               in_i,
  // Result output.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sfr_out_t              out_o,
  // Configuration writes.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pattern_bytes_q;
  logic [LEN_W-1:0]      pattern_length_q;
  logic [CFG_DATA_W-1:0] replacement_bytes_q;
  logic [LEN_W-1:0]      replacement_length_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_bytes_q      <= '0;
      pattern_length_q     <= '0;
      replacement_bytes_q  <= '0;
      replacement_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data_i;
        CFG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data_i[LEN_W-1:0];
        CFG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data_i;
        CFG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective lengths, clamped to the window and replacement capacities.
  logic [FILL_W-1:0] plen;
  logic [LEN_W-1:0]  rlen;

  assign plen = (pattern_length_q > LEN_W'(MAX_PATTERN)) ?
                FILL_W'(MAX_PATTERN) : FILL_W'(pattern_length_q);
  assign rlen = (replacement_length_q > LEN_W'(MAX_REPLACEMENT)) ?
                LEN_W'(MAX_REPLACEMENT) : replacement_length_q;

  // Sequencer state.
  logic                 busy_q, busy_d;
  logic                 end_q, end_d;
  logic                 emitted_q, emitted_d;
  logic                 rep_q, rep_d;
  logic [REP_IDX_W-1:0] rep_idx_q, rep_idx_d;
  logic [FILL_W-1:0]    fill_q, fill_d;

  // Window cells.
  sfr_cell_ctl_t        cell_ctl;
  logic [WIN_DEPTH-1:0] cell_load;
  logic [7:0]           cell_byte [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] eq_here, eq_prev, plen_mask, next_vec;
  logic                 cur_ok, next_ok;
  logic [WIN_IDX_W-1:0] ins_idx;
  logic                 buf_space, advance, accept;

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    logic [7:0] next_byte;
    logic [7:0] pat_prev;

    if (i == WIN_DEPTH - 1) begin : g_top
      assign next_byte = 8'h00;
    end else begin : g_mid
      assign next_byte = cell_byte[i+1];
    end

    if (i == 0) begin : g_first
      assign pat_prev = 8'h00;
    end else begin : g_rest
      assign pat_prev = pattern_bytes_q[(i-1)*8 +: 8];
    end

    assign plen_mask[i] = (FILL_W'(i) < plen);
    assign cell_load[i] = accept && (ins_idx == WIN_IDX_W'(i));

    sfr_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (cell_ctl),
      .load_i      (cell_load[i]),
      .load_byte_i (in_i.text_byte),
      .next_byte_i (next_byte),
      .pat_here_i  (pattern_bytes_q[i*8 +: 8]),
      .pat_prev_i  (pat_prev),
      .byte_o      (cell_byte[i]),
      .eq_here_o   (eq_here[i]),
      .eq_prev_o   (eq_prev[i])
    );

    // Window after one shift: cell i+1 against pattern byte i.
    if (i == WIN_DEPTH - 1) begin : g_next_top
      assign next_vec[i] = 1'b1;
    end else begin : g_next_mid
      assign next_vec[i] = eq_prev[i+1] || !plen_mask[i];
    end
  end

  assign cur_ok  = &(eq_here | ~plen_mask);
  assign next_ok = &next_vec;

  // One step of the sequencer: at most one result beat.
  logic                 st_emit, st_pop, st_clear, st_done, st_last, rep_start;
  sfr_out_t             st_res;
  logic [FILL_W-1:0]    fill_m1, step_fill;
  logic                 loop_now, match_now, cont, next_del, more, rep_last;
  logic [REP_IDX_W-1:0] rep_sel;
  logic [7:0]           rep_byte;

  assign fill_m1   = fill_q - FILL_W'(1);
  assign loop_now  = (fill_q != '0) && (fill_q >= plen);
  assign match_now = (plen != '0) && (fill_q == plen) && cur_ok;
  // Lookahead after popping the oldest byte, so run_last lands on the right beat.
  assign cont      = (fill_m1 != '0) && (fill_m1 >= plen);
  assign next_del  = cont && (plen != '0) && (fill_m1 == plen) && next_ok &&
                     (rlen == '0);
  assign more      = cont ? !next_del : (end_q && (fill_m1 != '0));
  assign rep_last  = (LEN_W'(rep_idx_q) == rlen - LEN_W'(1));
  assign rep_sel   = rep_q ? rep_idx_q : '0;
  assign rep_byte  = replacement_bytes_q[rep_sel*8 +: 8];

  always_comb begin
    st_emit   = 1'b0;
    st_pop    = 1'b0;
    st_clear  = 1'b0;
    st_done   = 1'b0;
    st_last   = 1'b0;
    rep_start = 1'b0;
    st_res    = '0;
    if (rep_q) begin
      st_emit = 1'b1;
      st_res.out_byte         = rep_byte;
      st_res.has_byte         = 1'b1;
      st_res.from_replacement = 1'b1;
      st_last = rep_last;
      st_done = rep_last;
    end else if (loop_now && match_now) begin
      st_clear = 1'b1;
      if (rlen != '0) begin
        st_emit = 1'b1;
        st_res.out_byte         = rep_byte;
        st_res.has_byte         = 1'b1;
        st_res.from_replacement = 1'b1;
        st_last   = (rlen == LEN_W'(1));
        st_done   = st_last;
        rep_start = !st_last;
      end else begin
        st_done = 1'b1;
        if (end_q && !emitted_q) begin
          st_emit = 1'b1;
          st_last = 1'b1;
        end
      end
    end else if (loop_now || (end_q && (fill_q != '0))) begin
      st_pop  = 1'b1;
      st_emit = 1'b1;
      st_res.out_byte = cell_byte[0];
      st_res.has_byte = 1'b1;
      st_last = !more;
      // A deletion that follows still needs its own sequencer step to clear the window.
      st_done = !more && !next_del;
    end else begin
      st_done = 1'b1;
      if (end_q && !emitted_q) begin
        st_emit = 1'b1;
        st_last = 1'b1;
      end
    end
    st_res.run_last   = st_last;
    st_res.stream_end = st_last && end_q;
  end

  // A new byte is taken when the window is idle or its current item finishes now.
  assign advance    = busy_q && (!st_emit || buf_space);
  assign in_stall_o = busy_q && !(advance && st_done);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (advance && st_clear) begin
      step_fill = '0;
    end else if (advance && st_pop) begin
      step_fill = fill_m1;
    end else begin
      step_fill = fill_q;
    end
  end

  assign ins_idx        = step_fill[WIN_IDX_W-1:0];
  assign fill_d         = accept ? step_fill + FILL_W'(1) : step_fill;
  assign cell_ctl.shift = advance && st_pop;
  assign cell_ctl.clear = advance && st_clear;

  always_comb begin
    busy_d    = busy_q;
    end_d     = end_q;
    emitted_d = emitted_q;
    rep_d     = rep_q;
    rep_idx_d = rep_idx_q;
    if (advance) begin
      if (st_done) begin
        busy_d = 1'b0;
      end
      if (st_emit) begin
        emitted_d = 1'b1;
      end
      if (rep_start) begin
        rep_d     = 1'b1;
        rep_idx_d = REP_IDX_W'(1);
      end else if (rep_q) begin
        rep_d     = !st_done;
        rep_idx_d = rep_idx_q + REP_IDX_W'(1);
      end
    end
    if (accept) begin
      busy_d    = 1'b1;
      end_d     = in_i.text_end;
      emitted_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      end_q     <= 1'b0;
      emitted_q <= 1'b0;
      rep_q     <= 1'b0;
      rep_idx_q <= '0;
      fill_q    <= '0;
    end else begin
      busy_q    <= busy_d;
      end_q     <= end_d;
      emitted_q <= emitted_d;
      rep_q     <= rep_d;
      rep_idx_q <= rep_idx_d;
      fill_q    <= fill_d;
    end
  end

  sfr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && st_emit),
    .push_data_i (st_res),
    .space_o     (buf_space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule

[hw/rtl/sfr_checker.sv]
// Port-level checks of the stream find-and-replace block and their binding.
`timescale 1ns / 1ps

module sfr_checker import sfr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input sfr_out_t out_o
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result beat changed");

  // A bare end beat is the only result of its input and closes the text.
  a_bare_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.has_byte |->
      out_o.run_last && out_o.stream_end && (out_o.out_byte == 8'h00) &&
      !out_o.from_replacement)
    else $error("malformed bare end beat");

  // The end of a text is always the last result of its input.
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.stream_end |-> out_o.run_last)
    else $error("stream_end without run_last");

  // Replacement beats always carry a byte.
  a_rep_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.from_replacement |-> out_o.has_byte)
    else $error("replacement beat without a byte");

endmodule

bind stream_find_and_replace sfr_checker u_sfr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);
